// ===== rtl/rrds_pkg.sv =====
package rrds_pkg;

    // action codes of an input item
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_DELAY = 1'b1;

    typedef struct packed {
        logic        action;
        logic [15:0] delay_ticks;
    } input_item_t;

    typedef struct packed {
        logic [1:0] running_task;
        logic [2:0] blocked_mask;
    } result_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_SCAN,
        S_FINISH
    } state_t;

    // controls shared by every cell of the chain
    typedef struct packed {
        logic count_down;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/rrds_cell.sv =====
module rrds_cell #(
    parameter int DELAY_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rrds_pkg::cell_ctrl_t    ctrl,
    input  logic                    write_en,
    input  logic [DELAY_BITS-1:0]   write_ticks,
    input  logic                    token_seed,
    input  logic                    token_in,
    output logic                    token_out,
    output logic                    blocked,
    output logic                    hit
);
    import rrds_pkg::*;

    logic [DELAY_BITS-1:0] count_reg;
    logic [DELAY_BITS-1:0] count_next;
    logic [DELAY_BITS-1:0] count_dec;
    logic                  blocked_reg;
    logic                  blocked_next;
    logic                  token_reg;
    logic                  token_next;

    assign count_dec = count_reg - DELAY_BITS'(1);

    always_comb
    begin
        count_next   = count_reg;
        blocked_next = blocked_reg;
        if (write_en)
        begin
            count_next   = write_ticks;
            blocked_next = 1'b1;
        end
        else if (ctrl.count_down && blocked_reg)
        begin
            count_next = count_dec;
            if (count_dec == '0)
            begin
                blocked_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (ctrl.load)
        begin
            token_next = token_seed;
        end
        else if (ctrl.shift)
        begin
            token_next = token_in;
        end
        else
        begin
            token_next = token_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            blocked_reg <= 1'b0;
            token_reg   <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            blocked_reg <= blocked_next;
            token_reg   <= token_next;
        end
    end

    assign token_out = token_reg;
    assign blocked   = blocked_reg;
    assign hit       = token_reg && !blocked_reg;

`ifndef NO_ASSERTIONS
    // a count that runs out always clears the blocked flag
    a_unblock_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.count_down && blocked_reg && !write_en && count_reg == DELAY_BITS'(1))
        |=> !blocked_reg)
        else $error("cell stayed blocked after its count ran out");

    // a blocked cell never holds a zero count
    a_blocked_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        blocked_reg |-> (count_reg != '0))
        else $error("blocked cell with zero count");

    // a write always blocks the cell with the written count
    a_write_loads: assert property (@(posedge clk) disable iff (!rst_n)
        write_en |=> (blocked_reg && count_reg == $past(write_ticks)))
        else $error("delay write not taken by cell");
`endif

endmodule

// ===== rtl/round_robin_delay_scheduler_core.sv =====
// round-robin task selector with tick delays
//
// input channel (in_valid / in_stall / in_data): one item is either a
// scheduler tick or a delay request for the current task. output channel
// (out_valid / out_stall / out_data): exactly one result per item, giving
// the selected task and the mask of blocked tasks after the update.
//
// per-task state lives in a chain of cells, one per task; a one-hot token
// rides the ring of user cells to find the next runnable task.
// a delay item goes from its transfer straight to the finish state, which
// loads the result register; a tick passes the count-down state, then the
// scan state (the token moves one cell per cycle) and then the finish
// state. one item is in work at a time; in_stall is high from the transfer
// of an item until its result is loaded. when the receiver stalls, the
// result holds in the output register; the next item may still be taken
// and worked up to its own result load.
// reset: task 1 is current, all tasks runnable, all counts zero, no
// result pending.
module round_robin_delay_scheduler_core #(
    parameter int NUM_TASKS  = 3,
    parameter int DELAY_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  rrds_pkg::input_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rrds_pkg::result_item_t out_data
);
    import rrds_pkg::*;

    localparam int TW = $clog2(NUM_TASKS);

    state_t             state_reg;
    state_t             state_next;
    logic [TW-1:0]      active_reg;
    logic [TW-1:0]      active_next;
    logic [TW-1:0]      cand_reg;
    logic [TW-1:0]      cand_next;
    logic [TW-1:0]      scan_reg;
    logic [TW-1:0]      scan_next;
    logic [TW-1:0]      start_idx;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_item_t       out_data_reg;
    result_item_t       out_data_next;

    cell_ctrl_t         ctrl;
    logic               in_xfer;
    logic               delay_ok;
    logic [DELAY_BITS-1:0] delay_val;
    logic               any_hit;

    logic [NUM_TASKS-1:0] write_en;
    logic [NUM_TASKS-1:0] token_seed;
    logic [NUM_TASKS-1:0] token_in;
    logic [NUM_TASKS-1:0] token_vec;
    logic [NUM_TASKS-1:0] blocked_vec;
    logic [NUM_TASKS-1:0] hit_vec;

    assign in_xfer   = in_valid && !in_stall;
    assign delay_val = DELAY_BITS'(in_data.delay_ticks);
    // delay counts only for a user task and a nonzero (truncated) count
    assign delay_ok  = in_xfer && (in_data.action == ACT_DELAY) &&
                       (active_reg != '0) && (delay_val != '0);
    assign any_hit   = |hit_vec;

    // scan starts at the task after the current one, wrapping to task 1
    assign start_idx = ((active_reg == '0) || (active_reg == TW'(NUM_TASKS - 1)))
                       ? TW'(1) : active_reg + TW'(1);

    genvar t;
    generate
        for (t = 0; t < NUM_TASKS; t++)
        begin : g_cell
            assign write_en[t] = delay_ok && (active_reg == TW'(t));

            if (t == 0)
            begin : g_idle
                // idle task never takes part in the rotation
                assign token_seed[t] = 1'b0;
                assign token_in[t]   = 1'b0;
            end
            else if (t == 1)
            begin : g_first
                assign token_seed[t] = (start_idx == TW'(t));
                assign token_in[t]   = token_vec[NUM_TASKS-1];
            end
            else
            begin : g_rest
                assign token_seed[t] = (start_idx == TW'(t));
                assign token_in[t]   = token_vec[t-1];
            end

            rrds_cell #(
                .DELAY_BITS (DELAY_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .write_en    (write_en[t]),
                .write_ticks (delay_val),
                .token_seed  (token_seed[t]),
                .token_in    (token_in[t]),
                .token_out   (token_vec[t]),
                .blocked     (blocked_vec[t]),
                .hit         (hit_vec[t])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= TW'(1);
            cand_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            cand_reg      <= cand_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        cand_next       = cand_reg;
        scan_next       = scan_reg;
        ctrl            = '0;
        in_stall        = 1'b1;
        out_data_next   = out_data_reg;
        // a pending result leaves once the receiver takes it
        out_valid_next  = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_xfer)
                begin
                    if (in_data.action == ACT_TICK)
                    begin
                        state_next = S_COUNT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_COUNT:
            begin
                // every blocked cell counts down, token seeded at start task
                ctrl.count_down = 1'b1;
                ctrl.load       = 1'b1;
                cand_next       = start_idx;
                scan_next       = '0;
                state_next      = S_SCAN;
            end
            S_SCAN:
            begin
                if (any_hit)
                begin
                    active_next = cand_reg;
                    state_next  = S_FINISH;
                end
                else if (scan_reg == TW'(NUM_TASKS - 2))
                begin
                    // no user task runnable
                    active_next = '0;
                    state_next  = S_FINISH;
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    cand_next  = (cand_reg == TW'(NUM_TASKS - 1))
                                 ? TW'(1) : cand_reg + TW'(1);
                    scan_next  = scan_reg + TW'(1);
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.running_task = 2'(active_reg);
                    out_data_next.blocked_mask = 3'(blocked_vec);
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // the scan token is a single bit while the ring is searched
    a_token_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> $onehot(token_vec))
        else $error("scan token not one-hot");

    // the idle task is never blocked
    a_idle_runnable: assert property (@(posedge clk) disable iff (!rst_n)
        !blocked_vec[0])
        else $error("idle task blocked");

    // the current task index stays within the task set
    a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= TW'(NUM_TASKS - 1))
        else $error("current task out of range");

    // a task picked by the scan is runnable
    a_pick_runnable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && any_hit) |=> !blocked_vec[active_reg])
        else $error("scan picked a blocked task");

    // a tick transfer goes through the count-down cycle
    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_data.action == ACT_TICK) |=> (state_reg == S_COUNT))
        else $error("tick skipped count-down");
`endif

endmodule
